@@ hw/rtl/hsd_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table of the Hall sine drive.
package hsd_pkg;

   localparam int ADC_W      = 12;
   localparam int ANG_W      = 16;
   localparam int SPD_W      = 20;
   localparam int CMP_W      = 16;
   localparam int MOD_W      = 16;
   localparam int PER_W      = 17;
   localparam int GAIN_W     = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int STEP_W     = 5;
   localparam int CORDIC_STEPS = 24;
   localparam int PI_DIVIDE  = 20;
   localparam int LANES      = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_REF = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INT_GAIN  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_PER   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_A  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_B  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_C  = 4'd7;

   // Datapath operations issued by the controller.
   typedef logic [4:0] op_type;
   localparam op_type OP_NONE    = 5'd0;
   localparam op_type OP_LOAD    = 5'd1;
   localparam op_type OP_SQX     = 5'd2;
   localparam op_type OP_MAG     = 5'd3;
   localparam op_type OP_VINIT   = 5'd4;
   localparam op_type OP_VSTEP   = 5'd5;
   localparam op_type OP_ANGLE   = 5'd6;
   localparam op_type OP_PRIME   = 5'd7;
   localparam op_type OP_SPEED   = 5'd8;
   localparam op_type OP_RAW     = 5'd9;
   localparam op_type OP_FILT    = 5'd10;
   localparam op_type OP_FUPD    = 5'd11;
   localparam op_type OP_PI_ERR  = 5'd12;
   localparam op_type OP_PI_IMUL = 5'd13;
   localparam op_type OP_PI_INT  = 5'd14;
   localparam op_type OP_PI_PMUL = 5'd15;
   localparam op_type OP_PI_OUT  = 5'd16;
   localparam op_type OP_RINIT   = 5'd17;
   localparam op_type OP_RSTEP   = 5'd18;
   localparam op_type OP_ZERO    = 5'd19;
   localparam op_type OP_MUL1    = 5'd20;
   localparam op_type OP_MUL2    = 5'd21;
   localparam op_type OP_MUL3    = 5'd22;
   localparam op_type OP_OUT     = 5'd23;

   typedef struct packed {
      op_type            op;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic vec_ok;
      logic primed;
      logic pi_due;
   } status_type;

   localparam logic signed [31:0] MAG_MIN      = 32'sd14400;
   localparam logic signed [15:0] SQRT3_Q14    = 16'sd28378;
   localparam logic signed [14:0] SPD_SCALE    = 15'sd9375;
   localparam logic signed [14:0] ALPHA_Q16    = 15'sd7864;
   localparam logic signed [50:0] MOD_MIN      = 51'sd343597384;
   localparam logic signed [50:0] MOD_MAX      = 51'sd3435973837;
   localparam logic signed [50:0] INTEG_MAX    = 51'sd549755813887;
   localparam logic signed [50:0] INTEG_MIN    = -51'sd549755813888;
   localparam logic signed [36:0] DUTY_MID     = 37'sd2147483648;
   localparam logic signed [36:0] DUTY_LO      = 37'sd85899346;
   localparam logic signed [36:0] DUTY_HI      = 37'sd4209067950;
   localparam logic [31:0]        THIRD_TURN   = 32'd1431655765;
   localparam logic [31:0]        QUARTER_FWD  = 32'h4000_0000;
   localparam logic [31:0]        QUARTER_REV  = 32'hC000_0000;
   localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
   localparam logic signed [33:0] GAIN_INV     = 34'sd652032875;
   localparam logic [PER_W-1:0]   PER_MAX      = 17'd65536;
   localparam logic signed [SPD_W-1:0] SPD_OUT_MAX = 20'sd524287;
   localparam logic signed [SPD_W-1:0] SPD_OUT_MIN = -20'sd524288;

   localparam logic signed [15:0]  SPEED_REF_RST = 16'sd400;
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST = 24'd1503239;
   localparam logic [GAIN_W-1:0]   INT_GAIN_RST  = 24'd6442;
   localparam logic [ADC_W-1:0]    OFFSET_RST    = 12'd1241;
   localparam logic signed [39:0]  INTEG_RST     = 40'sd343597384;
   localparam logic [MOD_W-1:0]    MOD_RST       = 16'd5243;

   // Arctangent of 2^-i in 32-bit turns.
   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/hsd_req_if.sv @@
// Input channel carrying the three Hall samples of one control tick.
interface hsd_req_if;
   import hsd_pkg::*;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] hall_a;
   logic [ADC_W-1:0] hall_b;
   logic [ADC_W-1:0] hall_c;
   modport source (output valid, output hall_a, output hall_b, output hall_c, input ready);
   modport sink   (input valid, input hall_a, input hall_b, input hall_c, output ready);
endinterface

@@ hw/rtl/hsd_rsp_if.sv @@
// Result channel carrying the compare values and status of one control tick.
interface hsd_rsp_if;
   import hsd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMP_W-1:0]        duty_a;
   logic [CMP_W-1:0]        duty_b;
   logic [CMP_W-1:0]        duty_c;
   logic                    fault;
   logic signed [ANG_W-1:0] elec_angle;
   logic signed [SPD_W-1:0] speed_rpm;
   logic [MOD_W-1:0]        modulation;
   modport source (output valid, output duty_a, output duty_b, output duty_c, output fault,
                   output elec_angle, output speed_rpm, output modulation, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c, input fault,
                   input elec_angle, input speed_rpm, input modulation, output ready);
endinterface

@@ hw/rtl/hall_sine_drive_speed_loop.sv @@
// Small-vector ticks skip the CORDIC steps, the priming tick runs only the vectoring, and a
// normal tick adds speed filter, PI update when due and rotation; the output may add a wait.
// Throughput: one tick at a time; the 24-step CORDIC vectoring and the 24-step rotation
// of the three phase lanes are most of the work. The next tick is taken while a result waits.
// Reset (synchronous, active high) restores the settings defaults and the loop state at once.
module hall_sine_drive_speed_loop (
   input  logic                           clock,
   input  logic                           reset,
   hsd_req_if.sink                        req_ch,
   hsd_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_en,
   input  logic [hsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hsd_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import hsd_pkg::*;

   cmd_type    cmd;
   status_type status;

   hsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hsd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .hall_a         (req_ch.hall_a),
      .hall_b         (req_ch.hall_b),
      .hall_c         (req_ch.hall_c),
      .duty_a         (rsp_ch.duty_a),
      .duty_b         (rsp_ch.duty_b),
      .duty_c         (rsp_ch.duty_c),
      .fault          (rsp_ch.fault),
      .elec_angle     (rsp_ch.elec_angle),
      .speed_rpm      (rsp_ch.speed_rpm),
      .modulation     (rsp_ch.modulation)
   );

endmodule

@@ hw/rtl/hsd_ctrl.sv @@
// Sequencer that steps the datapath through one control tick.
module hsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  hsd_pkg::status_type status,
   output hsd_pkg::cmd_type    cmd
);
   import hsd_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_SQX     = 5'd1;
   localparam logic [4:0] S_MAG     = 5'd2;
   localparam logic [4:0] S_CHECK   = 5'd3;
   localparam logic [4:0] S_VINIT   = 5'd4;
   localparam logic [4:0] S_VSTEP   = 5'd5;
   localparam logic [4:0] S_ANGLE   = 5'd6;
   localparam logic [4:0] S_PRIME   = 5'd7;
   localparam logic [4:0] S_SPEED   = 5'd8;
   localparam logic [4:0] S_RAW     = 5'd9;
   localparam logic [4:0] S_FILT    = 5'd10;
   localparam logic [4:0] S_FUPD    = 5'd11;
   localparam logic [4:0] S_PI_ERR  = 5'd12;
   localparam logic [4:0] S_PI_IMUL = 5'd13;
   localparam logic [4:0] S_PI_INT  = 5'd14;
   localparam logic [4:0] S_PI_PMUL = 5'd15;
   localparam logic [4:0] S_PI_OUT  = 5'd16;
   localparam logic [4:0] S_RINIT   = 5'd17;
   localparam logic [4:0] S_RSTEP   = 5'd18;
   localparam logic [4:0] S_ZERO    = 5'd19;
   localparam logic [4:0] S_MUL1    = 5'd20;
   localparam logic [4:0] S_MUL2    = 5'd21;
   localparam logic [4:0] S_MUL3    = 5'd22;
   localparam logic [4:0] S_OUT     = 5'd23;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic [4:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.step     = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SQX;
            end
         end
         S_SQX:   begin cmd.op = OP_SQX; state_in = S_MAG; end
         S_MAG:   begin cmd.op = OP_MAG; state_in = S_CHECK; end
         S_CHECK: begin state_in = status.vec_ok ? S_VINIT : S_ZERO; end
         S_VINIT: begin
            cmd.op   = OP_VINIT;
            step_in  = '0;
            state_in = S_VSTEP;
         end
         S_VSTEP: begin
            cmd.op = OP_VSTEP;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = S_ANGLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ANGLE: begin cmd.op = OP_ANGLE; state_in = status.primed ? S_SPEED : S_PRIME; end
         S_PRIME: begin cmd.op = OP_PRIME; state_in = S_ZERO; end
         S_SPEED: begin cmd.op = OP_SPEED; state_in = S_RAW; end
         S_RAW:   begin cmd.op = OP_RAW; state_in = S_FILT; end
         S_FILT:  begin cmd.op = OP_FILT; state_in = S_FUPD; end
         S_FUPD:  begin cmd.op = OP_FUPD; state_in = status.pi_due ? S_PI_ERR : S_RINIT; end
         S_PI_ERR:  begin cmd.op = OP_PI_ERR; state_in = S_PI_IMUL; end
         S_PI_IMUL: begin cmd.op = OP_PI_IMUL; state_in = S_PI_INT; end
         S_PI_INT:  begin cmd.op = OP_PI_INT; state_in = S_PI_PMUL; end
         S_PI_PMUL: begin cmd.op = OP_PI_PMUL; state_in = S_PI_OUT; end
         S_PI_OUT:  begin cmd.op = OP_PI_OUT; state_in = S_RINIT; end
         S_RINIT: begin
            cmd.op   = OP_RINIT;
            step_in  = '0;
            state_in = S_RSTEP;
         end
         S_RSTEP: begin
            cmd.op = OP_RSTEP;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = S_MUL1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ZERO: begin cmd.op = OP_ZERO; state_in = S_MUL1; end
         S_MUL1: begin cmd.op = OP_MUL1; state_in = S_MUL2; end
         S_MUL2: begin cmd.op = OP_MUL2; state_in = S_MUL3; end
         S_MUL3: begin cmd.op = OP_MUL3; state_in = S_OUT; end
         S_OUT: begin
            // The result register is loaded only once the previous transfer has gone out.
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/hsd_dp.sv @@
// Datapath: settings registers, CORDIC lanes, speed filter, PI loop and PWM compare math.
module hsd_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [hsd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hsd_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  hsd_pkg::cmd_type                      cmd,
   output hsd_pkg::status_type                   status,
   input  logic [hsd_pkg::ADC_W-1:0]             hall_a,
   input  logic [hsd_pkg::ADC_W-1:0]             hall_b,
   input  logic [hsd_pkg::ADC_W-1:0]             hall_c,
   output logic [hsd_pkg::CMP_W-1:0]             duty_a,
   output logic [hsd_pkg::CMP_W-1:0]             duty_b,
   output logic [hsd_pkg::CMP_W-1:0]             duty_c,
   output logic                                  fault,
   output logic signed [hsd_pkg::ANG_W-1:0]      elec_angle,
   output logic signed [hsd_pkg::SPD_W-1:0]      speed_rpm,
   output logic [hsd_pkg::MOD_W-1:0]             modulation
);
   import hsd_pkg::*;

   // Settings registers.
   logic signed [15:0]     ref_ff;
   logic [GAIN_W-1:0]      pgain_ff, igain_ff;
   logic [PER_W-1:0]       period_ff;
   logic                   rev_ff;
   logic [ADC_W-1:0]       off_a_ff, off_b_ff, off_c_ff;

   // Loop state.
   logic                   primed_ff;
   logic [ANG_W-1:0]       prev_ff;
   logic signed [31:0]     sf_ff;
   logic signed [39:0]     integ_ff;
   logic [MOD_W-1:0]       mod_ff;
   logic [4:0]             cnt_ff;

   // Working registers.
   logic signed [15:0]     x_ff;
   logic signed [14:0]     d_ff;
   logic signed [31:0]     sqx_ff;
   logic                   vec_ok_ff;
   logic [ANG_W-1:0]       ang_ff;
   logic signed [30:0]     spd_prod_ff;
   logic signed [30:0]     raw_ff;
   logic signed [47:0]     fprod_ff;
   logic signed [32:0]     e8_ff;
   logic signed [57:0]     mprod_ff;
   logic signed [39:0]     ni_ff;
   logic                   fault_ff;
   logic signed [33:0]     cx_ff [LANES];
   logic signed [33:0]     cy_ff [LANES];
   logic signed [33:0]     cz_ff [LANES];
   logic signed [50:0]     sp_ff [LANES];
   logic [31:0]            duty_ff [LANES];
   logic [CMP_W-1:0]       cmp_ff [LANES];

   // Result register.
   logic [CMP_W-1:0]        out_duty_ff [LANES];
   logic                    out_fault_ff;
   logic signed [ANG_W-1:0] out_ang_ff;
   logic signed [SPD_W-1:0] out_spd_ff;
   logic [MOD_W-1:0]        out_mod_ff;

   // Combinational helpers.
   logic signed [12:0]     sa, sb, sc;
   logic signed [15:0]     x_val;
   logic signed [14:0]     d_val;
   logic signed [31:0]     dd, mag;
   logic signed [33:0]     xi, yi, at;
   logic signed [33:0]     shx [LANES];
   logic signed [33:0]     shy [LANES];
   logic [31:0]            zsum, drive;
   logic [31:0]            tw [LANES];
   logic [ANG_W-1:0]       ud;
   logic signed [30:0]     rsum;
   logic signed [32:0]     diff;
   logic signed [47:0]     fsum;
   logic [4:0]             cnt_inc;
   logic signed [50:0]     ni_sum, raw_pi, o_pi;
   logic [32:0]            o_rnd;
   logic                   e8_neg, e8_pos, commit;
   logic signed [36:0]     dsum [LANES];
   logic [PER_W-1:0]       per_eff;
   logic [48:0]            cprod [LANES];
   logic signed [32:0]     sr;
   logic [GAIN_W-1:0]      mgain;

   always_comb begin
      sa    = $signed({1'b0, hall_a}) - $signed({1'b0, off_a_ff});
      sb    = $signed({1'b0, hall_b}) - $signed({1'b0, off_b_ff});
      sc    = $signed({1'b0, hall_c}) - $signed({1'b0, off_c_ff});
      x_val = $signed({{2{sa[12]}}, sa, 1'b0}) - $signed({{3{sb[12]}}, sb})
              - $signed({{3{sc[12]}}, sc});
      d_val = $signed({{2{sb[12]}}, sb}) - $signed({{2{sc[12]}}, sc});

      dd  = d_ff * d_ff;
      mag = sqx_ff + dd + (dd <<< 1);

      xi = $signed({{4{x_ff[15]}}, x_ff, 14'b0});
      yi = d_ff * SQRT3_Q14;
      at = $signed({2'b00, atan_turn(cmd.step)});
      for (int l = 0; l < LANES; l++) begin
         shx[l] = cx_ff[l] >>> cmd.step;
         shy[l] = cy_ff[l] >>> cmd.step;
      end

      zsum  = cz_ff[0][31:0] + 32'h0000_8000;
      drive = {ang_ff, 16'b0} + (rev_ff ? QUARTER_REV : QUARTER_FWD);
      tw[0] = drive;
      tw[1] = drive - THIRD_TURN;
      tw[2] = drive + THIRD_TURN;
      // Fold the second and third quadrants onto the first and fourth.
      for (int l = 0; l < LANES; l++) begin
         if (tw[l][31:30] == 2'b01 || tw[l][31:30] == 2'b10) begin
            tw[l] = HALF_TURN - tw[l];
         end
      end

      ud   = ang_ff - prev_ff;
      rsum = spd_prod_ff + (spd_prod_ff[30] ? 31'sd3 : 31'sd0);
      diff = $signed({{2{raw_ff[30]}}, raw_ff}) - $signed({sf_ff[31], sf_ff});
      fsum = fprod_ff + 48'sd32768;
      cnt_inc = cnt_ff + 5'd1;

      mgain  = cmd.op == OP_PI_IMUL ? igain_ff : pgain_ff;
      ni_sum = $signed({{11{integ_ff[39]}}, integ_ff})
               + $signed({mprod_ff[57], mprod_ff[57:8]});
      raw_pi = $signed({mprod_ff[57], mprod_ff[57:8]})
               + $signed({{11{ni_ff[39]}}, ni_ff});
      if (raw_pi < MOD_MIN) begin
         o_pi = MOD_MIN;
      end else if (raw_pi > MOD_MAX) begin
         o_pi = MOD_MAX;
      end else begin
         o_pi = raw_pi;
      end
      o_rnd  = o_pi[32:0] + 33'd32768;
      e8_neg = e8_ff[32];
      e8_pos = !e8_ff[32] && (e8_ff != 33'sd0);
      // Conditional integration: keep the new integrator unless it pushes deeper into a limit.
      commit = (raw_pi == o_pi) || (raw_pi > MOD_MAX && e8_neg) || (raw_pi < MOD_MIN && e8_pos);

      per_eff = period_ff > PER_MAX ? PER_MAX : period_ff;
      for (int l = 0; l < LANES; l++) begin
         dsum[l]  = DUTY_MID + $signed({sp_ff[l][50], sp_ff[l][50:15]});
         cprod[l] = {17'b0, duty_ff[l]} * {32'b0, per_eff} + 49'h0_8000_0000;
      end

      sr = ($signed({sf_ff[31], sf_ff}) + 33'sd128) >>> 8;
   end

   assign status.vec_ok = vec_ok_ff;
   assign status.primed = primed_ff;
   assign status.pi_due = cnt_inc >= 5'(PI_DIVIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= SPEED_REF_RST;
         pgain_ff  <= PROP_GAIN_RST;
         igain_ff  <= INT_GAIN_RST;
         period_ff <= PER_MAX;
         rev_ff    <= 1'b0;
         off_a_ff  <= OFFSET_RST;
         off_b_ff  <= OFFSET_RST;
         off_c_ff  <= OFFSET_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_SPEED_REF: ref_ff    <= $signed(csr_write_data[15:0]);
            REG_PROP_GAIN: pgain_ff  <= csr_write_data;
            REG_INT_GAIN:  igain_ff  <= csr_write_data;
            REG_PWM_PER:   period_ff <= csr_write_data[PER_W-1:0];
            REG_REVERSE:   rev_ff    <= csr_write_data[0];
            REG_OFFSET_A:  off_a_ff  <= csr_write_data[ADC_W-1:0];
            REG_OFFSET_B:  off_b_ff  <= csr_write_data[ADC_W-1:0];
            REG_OFFSET_C:  off_c_ff  <= csr_write_data[ADC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         prev_ff   <= '0;
         sf_ff     <= '0;
         integ_ff  <= INTEG_RST;
         mod_ff    <= MOD_RST;
         cnt_ff    <= '0;
      end else begin
         unique case (cmd.op)
            OP_PRIME: begin
               prev_ff   <= ang_ff;
               primed_ff <= 1'b1;
            end
            OP_FUPD: begin
               sf_ff   <= sf_ff + fsum[47:16];
               prev_ff <= ang_ff;
               cnt_ff  <= status.pi_due ? 5'd0 : cnt_inc;
            end
            OP_PI_OUT: begin
               if (commit) begin
                  integ_ff <= ni_ff;
               end
               mod_ff <= o_rnd[31:16];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op) inside
         OP_LOAD: begin
            x_ff <= x_val;
            d_ff <= d_val;
         end
         OP_SQX: sqx_ff <= x_ff * x_ff;
         OP_MAG: vec_ok_ff <= mag >= MAG_MIN;
         OP_VINIT: begin
            // Move the vector into the right half plane before the micro-rotations.
            if (x_ff[15]) begin
               cx_ff[0] <= -xi;
               cy_ff[0] <= -yi;
               cz_ff[0] <= $signed({2'b00, HALF_TURN});
            end else begin
               cx_ff[0] <= xi;
               cy_ff[0] <= yi;
               cz_ff[0] <= '0;
            end
         end
         OP_VSTEP: begin
            if (!cy_ff[0][33]) begin
               cx_ff[0] <= cx_ff[0] + shy[0];
               cy_ff[0] <= cy_ff[0] - shx[0];
               cz_ff[0] <= cz_ff[0] + at;
            end else begin
               cx_ff[0] <= cx_ff[0] - shy[0];
               cy_ff[0] <= cy_ff[0] + shx[0];
               cz_ff[0] <= cz_ff[0] - at;
            end
         end
         OP_ANGLE: ang_ff <= zsum[31:16];
         OP_SPEED: spd_prod_ff <= $signed(ud) * SPD_SCALE;
         OP_RAW:   raw_ff <= rsum >>> 2;
         OP_FILT:  fprod_ff <= diff * ALPHA_Q16;
         OP_PI_ERR: e8_ff <= $signed({{9{ref_ff[15]}}, ref_ff, 8'b0}) - $signed({sf_ff[31], sf_ff});
         OP_PI_IMUL, OP_PI_PMUL: mprod_ff <= $signed({1'b0, mgain}) * e8_ff;
         OP_PI_INT: begin
            if (ni_sum > INTEG_MAX) begin
               ni_ff <= INTEG_MAX[39:0];
            end else if (ni_sum < INTEG_MIN) begin
               ni_ff <= INTEG_MIN[39:0];
            end else begin
               ni_ff <= ni_sum[39:0];
            end
         end
         OP_RINIT: begin
            fault_ff <= 1'b0;
            for (int l = 0; l < LANES; l++) begin
               cx_ff[l] <= GAIN_INV;
               cy_ff[l] <= '0;
               cz_ff[l] <= $signed({{2{tw[l][31]}}, tw[l]});
            end
         end
         OP_RSTEP: begin
            for (int l = 0; l < LANES; l++) begin
               if (!cz_ff[l][33]) begin
                  cx_ff[l] <= cx_ff[l] - shy[l];
                  cy_ff[l] <= cy_ff[l] + shx[l];
                  cz_ff[l] <= cz_ff[l] - at;
               end else begin
                  cx_ff[l] <= cx_ff[l] + shy[l];
                  cy_ff[l] <= cy_ff[l] - shx[l];
                  cz_ff[l] <= cz_ff[l] + at;
               end
            end
         end
         OP_ZERO: begin
            // A zero sine gives the 50% compare value on every phase.
            fault_ff <= 1'b1;
            for (int l = 0; l < LANES; l++) begin
               cy_ff[l] <= '0;
            end
         end
         OP_MUL1: begin
            for (int l = 0; l < LANES; l++) begin
               sp_ff[l] <= $signed({1'b0, mod_ff}) * cy_ff[l];
            end
         end
         OP_MUL2: begin
            for (int l = 0; l < LANES; l++) begin
               if (dsum[l] < DUTY_LO) begin
                  duty_ff[l] <= DUTY_LO[31:0];
               end else if (dsum[l] > DUTY_HI) begin
                  duty_ff[l] <= DUTY_HI[31:0];
               end else begin
                  duty_ff[l] <= dsum[l][31:0];
               end
            end
         end
         OP_MUL3: begin
            for (int l = 0; l < LANES; l++) begin
               cmp_ff[l] <= cprod[l][47:32];
            end
         end
         OP_OUT: begin
            for (int l = 0; l < LANES; l++) begin
               out_duty_ff[l] <= cmp_ff[l];
            end
            out_fault_ff <= fault_ff;
            out_ang_ff   <= $signed(prev_ff);
            out_mod_ff   <= mod_ff;
            if (sr > $signed({{13{SPD_OUT_MAX[SPD_W-1]}}, SPD_OUT_MAX})) begin
               out_spd_ff <= SPD_OUT_MAX;
            end else if (sr < $signed({{13{SPD_OUT_MIN[SPD_W-1]}}, SPD_OUT_MIN})) begin
               out_spd_ff <= SPD_OUT_MIN;
            end else begin
               out_spd_ff <= sr[SPD_W-1:0];
            end
         end
         default: ;
      endcase
   end

   assign duty_a     = out_duty_ff[0];
   assign duty_b     = out_duty_ff[1];
   assign duty_c     = out_duty_ff[2];
   assign fault      = out_fault_ff;
   assign elec_angle = out_ang_ff;
   assign speed_rpm  = out_spd_ff;
   assign modulation = out_mod_ff;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the Hall sine drive speed loop: stimulus, predictor and checker.
`timescale 1ns / 100ps
module tb_top;
   import hsd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd15;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_HOLD = 600;
   localparam longint MOD_LO_Q32 = 64'sd343597384;
   localparam longint MOD_HI_Q32 = 64'sd3435973837;
   localparam longint INTEG_TOP  = 64'sd549755813887;
   localparam longint DUTY_MIN   = 64'sd85899346;
   localparam longint DUTY_MAX   = 64'sd4209067950;
   localparam longint HALF_Q32   = 64'sd2147483648;

   localparam logic [31:0] ATAN_TBL [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   typedef struct {
      logic [ADC_W-1:0] a, b, c;
   } hall_sample_type;

   typedef struct {
      logic [CMP_W-1:0]        duty_a, duty_b, duty_c;
      logic                    fault;
      logic signed [ANG_W-1:0] angle;
      logic signed [SPD_W-1:0] rpm;
      logic [MOD_W-1:0]        modulation;
   } drive_out_type;

   logic clock, reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   hsd_req_if req ();
   hsd_rsp_if rsp ();

   hall_sine_drive_speed_loop uut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   // Settings mirrored by the predictor.
   longint set_ref, set_kp, set_ki, set_period, set_rev;
   longint set_off [3];
   // Loop state mirrored by the predictor.
   logic        st_primed;
   logic [15:0] st_angle;
   longint      st_filter, st_integ, st_mod;
   int          st_pi_count;

   hall_sample_type pending_ticks [$];
   drive_out_type   expected_outputs [$];
   bit calm;
   int mismatches, ticks_sent, results_seen, faults_seen;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] field_turns(longint x, longint y);
      logic [31:0] z;
      longint dx, dy;
      z = 32'h0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF_TURN;
      end
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_TBL[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_TBL[i];
         end
      end
      return z;
   endfunction

   function automatic longint sine_q30(logic [31:0] t);
      longint x, y, z, dx, dy;
      if (t[31:30] == 2'd1 || t[31:30] == 2'd2) t = HALF_TURN - t;
      z = longint'($signed(t));
      x = 64'sd652032875;
      y = 0;
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
         end
      end
      return y;
   endfunction

   function automatic logic [15:0] compare_value(longint s30, longint per);
      longint d, r;
      d = HALF_Q32 + ((st_mod * s30) >>> 15);
      if (d < DUTY_MIN) d = DUTY_MIN;
      if (d > DUTY_MAX) d = DUTY_MAX;
      r = (d * per + HALF_Q32) >>> 32;
      return r[15:0];
   endfunction

   function automatic logic [15:0] round_angle(logic [31:0] z);
      logic [32:0] t;
      t = {1'b0, z} + 33'h8000;
      return t[31:16];
   endfunction

   task automatic update_speed_loop();
      longint e8, ni, raw, o;
      e8 = set_ref * 256 - st_filter;
      ni = st_integ + ((set_ki * e8) >>> 8);
      if (ni > INTEG_TOP) ni = INTEG_TOP;
      if (ni < -INTEG_TOP - 1) ni = -INTEG_TOP - 1;
      raw = ((set_kp * e8) >>> 8) + ni;
      o = raw < MOD_LO_Q32 ? MOD_LO_Q32 : (raw > MOD_HI_Q32 ? MOD_HI_Q32 : raw);
      if (raw == o || (raw > MOD_HI_Q32 && e8 < 0) || (raw < MOD_LO_Q32 && e8 > 0))
         st_integ = ni;
      st_mod = ((o + 32768) >>> 16) & 64'hFFFF;
   endtask

   task automatic predict_tick(hall_sample_type s);
      longint la, lb, lc, x, d, mag, per, delta, raw8, rpm;
      logic [15:0] ang, ud;
      logic [31:0] drive;
      drive_out_type r;
      la = longint'(s.a) - set_off[0];
      lb = longint'(s.b) - set_off[1];
      lc = longint'(s.c) - set_off[2];
      x = 2 * la - lb - lc;
      d = lb - lc;
      mag = x * x + 3 * d * d;
      per = set_period > 65536 ? 65536 : set_period;
      if (mag < 14400 || !st_primed) begin
         if (mag >= 14400) begin
            st_angle = round_angle(field_turns(x * 16384, d * 28378));
            st_primed = 1'b1;
         end
         r.fault = 1'b1;
         r.duty_a = compare_value(0, per);
         r.duty_b = r.duty_a;
         r.duty_c = r.duty_a;
      end else begin
         ang = round_angle(field_turns(x * 16384, d * 28378));
         ud = ang - st_angle;
         delta = longint'($signed(ud));
         raw8 = delta * 64'sd307200000 / 64'sd131072;
         st_filter += ((raw8 - st_filter) * 7864 + 32768) >>> 16;
         st_angle = ang;
         st_pi_count = (st_pi_count + 1) & 31;
         if (st_pi_count >= PI_DIVIDE) begin
            st_pi_count = 0;
            update_speed_loop();
         end
         drive = {ang, 16'h0} + (set_rev != 0 ? QUARTER_REV : QUARTER_FWD);
         r.duty_a = compare_value(sine_q30(drive), per);
         r.duty_b = compare_value(sine_q30(drive - THIRD_TURN), per);
         r.duty_c = compare_value(sine_q30(drive + THIRD_TURN), per);
         r.fault = 1'b0;
      end
      rpm = (st_filter + 128) >>> 8;
      if (rpm > 524287) rpm = 524287;
      if (rpm < -524288) rpm = -524288;
      r.angle = st_angle;
      r.rpm = rpm[SPD_W-1:0];
      r.modulation = st_mod[15:0];
      expected_outputs.push_back(r);
   endtask

   // Driver: presents queued ticks with a random gap drawn for each one, or none when calm.
   hall_sample_type cur_tick;
   int gap_left;
   always @(posedge clock) begin
      logic busy;
      busy = req.valid;
      if (reset) begin
         req.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req.valid && req.ready) begin
            predict_tick(cur_tick);
            ticks_sent++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               cur_tick = pending_ticks.pop_front();
               req.hall_a <= cur_tick.a;
               req.hall_b <= cur_tick.b;
               req.hall_c <= cur_tick.c;
               req.valid <= 1'b1;
               gap_left = calm ? 0 : $urandom_range(0, 18);
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // One long hold-off on the result side so that the block backs up into its input.
   int stall_left, hold_left;
   bit hold_done;
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (!hold_done && results_seen >= 300) begin
         hold_left = LONG_HOLD;
         hold_done = 1'b1;
      end
   end

   // Monitor: checks every result transfer and throttles ready.
   always @(posedge clock) begin
      drive_out_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (rsp.fault) faults_seen++;
            if (expected_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Result with nothing expected at cycle %0d", cycles);
            end else begin
               e = expected_outputs.pop_front();
               if (rsp.duty_a !== e.duty_a || rsp.duty_b !== e.duty_b ||
                   rsp.duty_c !== e.duty_c || rsp.fault !== e.fault ||
                   rsp.elec_angle !== e.angle || rsp.speed_rpm !== e.rpm ||
                   rsp.modulation !== e.modulation) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch #%0d: expected %0d %0d %0d f%0d ang %0d rpm %0d mod %0d",
                              results_seen, e.duty_a, e.duty_b, e.duty_c, e.fault, e.angle,
                              e.rpm, e.modulation);
                     $display("   got %0d %0d %0d f%0d ang %0d rpm %0d mod %0d",
                              rsp.duty_a, rsp.duty_b, rsp.duty_c, rsp.fault,
                              rsp.elec_angle, rsp.speed_rpm, rsp.modulation);
                  end
               end
            end
            stall_left = calm ? 0 : $urandom_range(0, 18);
         end
         if (hold_left > 0) begin
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint value);
      logic [23:0] v;
      v = value[23:0];
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_SPEED_REF: set_ref = longint'($signed(v[15:0]));
         REG_PROP_GAIN: set_kp = v;
         REG_INT_GAIN:  set_ki = v;
         REG_PWM_PER:   set_period = v[16:0];
         REG_REVERSE:   set_rev = v[0];
         REG_OFFSET_A:  set_off[0] = v[11:0];
         REG_OFFSET_B:  set_off[1] = v[11:0];
         REG_OFFSET_C:  set_off[2] = v[11:0];
         default: ;
      endcase
   endtask

   // Checked between edges so that the driver's updates of the same edge are visible.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_ticks.size() > 0 || req.valid || expected_outputs.size() > 0)
         @(negedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [11:0] clip_adc(longint v);
      if (v < 0) return 12'd0;
      if (v > 4095) return 12'd4095;
      return v[11:0];
   endfunction

   task automatic push_tick(longint a, longint b, longint c);
      hall_sample_type s;
      s.a = clip_adc(a);
      s.b = clip_adc(b);
      s.c = clip_adc(c);
      pending_ticks.push_back(s);
   endtask

   // A rotating field with random amplitude and speed, centered on the offsets.
   task automatic push_rotation(int n);
      real theta, stp, amp;
      theta = $urandom_range(0, 6283) / 1000.0;
      stp = ($urandom_range(0, 1600) - 800.0) / 1000.0;
      amp = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(60, 2000);
      for (int k = 0; k < n; k++) begin
         push_tick(set_off[0] + $rtoi(amp * $cos(theta)),
                   set_off[1] + $rtoi(amp * $cos(theta - 2.0943951)),
                   set_off[2] + $rtoi(amp * $cos(theta + 2.0943951)));
         theta += stp;
      end
   endtask

   task automatic random_ticks(int n);
      int done, len, kind;
      done = 0;
      while (done < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            len = $urandom_range(5, 60);
            push_rotation(len);
            done += len;
         end else if (kind < 90) begin
            push_tick($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
            done++;
         end else begin
            push_tick(set_off[0] + $urandom_range(0, 30) - 15,
                      set_off[1] + $urandom_range(0, 30) - 15,
                      set_off[2] + $urandom_range(0, 30) - 15);
            done++;
         end
      end
   endtask

   task automatic program_all(longint sref, longint kp, longint ki, longint per, longint rev,
                              longint oa, longint ob, longint oc);
      wait_idle();
      write_reg(REG_SPEED_REF, sref);
      write_reg(REG_PROP_GAIN, kp);
      write_reg(REG_INT_GAIN, ki);
      write_reg(REG_PWM_PER, per);
      write_reg(REG_REVERSE, rev);
      write_reg(REG_OFFSET_A, oa);
      write_reg(REG_OFFSET_B, ob);
      write_reg(REG_OFFSET_C, oc);
      calm = ($urandom_range(0, 2) == 0);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.hall_a = '0;
      req.hall_b = '0;
      req.hall_c = '0;
      rsp.ready = 1'b0;
      calm = 1'b0;
      mismatches = 0; ticks_sent = 0; results_seen = 0; faults_seen = 0; cycles = 0;
      set_ref = 400; set_kp = 1503239; set_ki = 6442; set_period = 65536; set_rev = 0;
      set_off = '{1241, 1241, 1241};
      st_primed = 1'b0; st_angle = '0; st_filter = 0;
      st_integ = MOD_LO_Q32; st_mod = 5243; st_pi_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset settings: zero and saturated inputs, the
      // magnitude threshold from both sides, priming, and a half-turn jump.
      push_tick(1241, 1241, 1241);
      push_tick(0, 0, 0);
      push_tick(4095, 4095, 4095);
      push_tick(1279, 1222, 1222);
      push_tick(1281, 1221, 1221);
      push_tick(4095, 0, 0);
      push_tick(0, 4095, 4095);
      push_tick(0, 4095, 0);
      push_tick(4095, 4095, 0);
      push_tick(1641, 1041, 1041);
      push_tick(841, 1441, 1441);
      push_tick(1641, 1041, 1041);
      push_tick(1240, 1242, 1241);
      push_rotation(12);
      random_ticks(200);

      // The unused register index must leave every setting alone.
      wait_idle();
      write_reg(REG_UNUSED, 24'hFFFFFF);
      random_ticks(40);

      program_all(30000, 16777215, 16777215, 65536, 0, 1241, 1241, 1241);
      random_ticks(220);
      program_all(-30000, 0, 0, 1, 1, 0, 4095, 2048);
      random_ticks(180);
      program_all($urandom_range(0, 65535), $urandom_range(0, 16777215), $urandom_range(0, 65535),
                  0, 0, $urandom_range(800, 3000), $urandom_range(800, 3000),
                  $urandom_range(800, 3000));
      random_ticks(180);
      program_all(-1500, 3000000, 200000, 131071, 1, 2048, 2048, 2048);
      random_ticks(220);
      program_all($urandom_range(0, 65535), $urandom_range(0, 16777215),
                  $urandom_range(0, 16777215), $urandom_range(1, 65536), $urandom_range(0, 1),
                  1241, 1300, 1180);
      random_ticks(220);

      wait_idle();
      mismatches += expected_outputs.size();
      $display("Run covered %0d ticks over six register settings, %0d results checked, %0d faults.",
               ticks_sent, results_seen, faults_seen);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
